// File: rtl/ptm_pkg.sv
// shared types, character codes and tone mark table for the pinyin tone marker
`timescale 1ns / 1ps
package ptm_pkg;

    typedef struct packed {
        logic [15:0] in_char;
        logic        end_of_string;
    } item_t;

    typedef struct packed {
        logic [15:0] out_char;
        logic        run_last;
        logic        overflowed;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic take_item;
        logic emit_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic run_start;
        logic emit_last;
    } stat_t;

    localparam logic [15:0] CH_0     = 16'h0030;
    localparam logic [15:0] CH_1     = 16'h0031;
    localparam logic [15:0] CH_5     = 16'h0035;
    localparam logic [15:0] CH_9     = 16'h0039;
    localparam logic [15:0] CH_UP_A  = 16'h0041;
    localparam logic [15:0] CH_UP_Z  = 16'h005A;
    localparam logic [15:0] CASE_OFS = 16'h0020;
    localparam logic [15:0] CH_A     = 16'h0061;
    localparam logic [15:0] CH_E     = 16'h0065;
    localparam logic [15:0] CH_I     = 16'h0069;
    localparam logic [15:0] CH_O     = 16'h006F;
    localparam logic [15:0] CH_U     = 16'h0075;

    // vowel row codes, one row of four tones each
    localparam logic [2:0] V_A = 3'd0;
    localparam logic [2:0] V_E = 3'd1;
    localparam logic [2:0] V_I = 3'd2;
    localparam logic [2:0] V_O = 3'd3;
    localparam logic [2:0] V_U = 3'd4;

    localparam int TONE_ROWS = 20;

    // macron, acute, caron, grave per vowel
    localparam logic [15:0] TONE_TABLE [TONE_ROWS] = '{
        16'h0101, 16'h00E1, 16'h01CE, 16'h00E0,
        16'h0113, 16'h00E9, 16'h011B, 16'h00E8,
        16'h012B, 16'h00ED, 16'h01D0, 16'h00EC,
        16'h014D, 16'h00F3, 16'h01D2, 16'h00F2,
        16'h016B, 16'h00FA, 16'h01D4, 16'h00F9
    };

endpackage

// File: rtl/ptm_ctrl.sv
// controller: takes requests, steps syllable out one character a cycle unless stalled
`timescale 1ns / 1ps
module ptm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    output logic          result_valid,
    input  logic          result_stall,
    input  ptm_pkg::stat_t stat,
    output ptm_pkg::cmd_t  cmd
);
    import ptm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_space;

    assign out_space     = !out_valid_reg || !result_stall;
    assign item_stall    = (state_reg != ST_IDLE);
    assign cmd.take_item = item_valid && (state_reg == ST_IDLE);
    assign cmd.emit_step = (state_reg == ST_EMIT) && out_space;
    assign result_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.take_item && stat.run_start)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit_step && stat.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.emit_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/ptm_dpath.sv
// syllable buffer, running vowel trackers, tone mark lookup and output register
`timescale 1ns / 1ps
module ptm_dpath #(
    parameter int MAX_SYLLABLE = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ptm_pkg::item_t   item,
    input  ptm_pkg::cmd_t    cmd,
    output ptm_pkg::stat_t   stat,
    output ptm_pkg::result_t result
);
    import ptm_pkg::*;

    localparam int CW = $clog2(MAX_SYLLABLE + 1);
    localparam int IW = $clog2(MAX_SYLLABLE);

    logic [15:0]   store_mem [MAX_SYLLABLE];
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] idx_reg, idx_next;

    // first a, e, o and last i or u seen so far
    logic          has_a_reg, has_e_reg, has_o_reg, has_iu_reg;
    logic          has_a_next, has_e_next, has_o_next, has_iu_next;
    logic [IW-1:0] pos_a_reg, pos_e_reg, pos_o_reg, pos_iu_reg;
    logic [IW-1:0] pos_a_next, pos_e_next, pos_o_next, pos_iu_next;
    logic          iu_is_u_reg, iu_is_u_next;

    logic [15:0]   mark_reg;
    logic          marked_reg;
    logic [IW-1:0] pos_reg;
    result_t       result_reg;

    logic          is_eos, is_digit, is_tone, is_tone5, is_full, do_write, do_clear;
    logic [15:0]   folded;
    logic [IW-1:0] wr_idx;
    logic          any_vowel;
    logic [2:0]    vcode;
    logic [IW-1:0] vpos;
    logic [1:0]    tone_ofs;

    assign is_eos   = item.end_of_string;
    assign is_digit = (item.in_char >= CH_0) && (item.in_char <= CH_9);
    assign is_tone  = (item.in_char >= CH_1) && (item.in_char <= CH_5);
    assign is_tone5 = (item.in_char == CH_5);
    assign is_full  = (count_reg >= CW'(MAX_SYLLABLE));
    assign folded   = ((item.in_char >= CH_UP_A) && (item.in_char <= CH_UP_Z))
                      ? (item.in_char + CASE_OFS) : item.in_char;
    assign wr_idx   = count_reg[IW-1:0];
    assign do_write = cmd.take_item && !is_eos && !is_digit && !is_full;
    assign tone_ofs = item.in_char[1:0] - 2'd1;

    assign stat.run_start = !is_eos && is_tone && (count_reg != '0);
    assign stat.emit_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign do_clear = (cmd.take_item && is_eos) || (cmd.emit_step && stat.emit_last);

    assign any_vowel = has_a_reg || has_e_reg || has_o_reg || has_iu_reg;

    always_comb
    begin
        priority if (has_a_reg)
        begin
            vcode = V_A;
            vpos  = pos_a_reg;
        end
        else if (has_e_reg)
        begin
            vcode = V_E;
            vpos  = pos_e_reg;
        end
        else if (has_o_reg)
        begin
            vcode = V_O;
            vpos  = pos_o_reg;
        end
        else
        begin
            vcode = iu_is_u_reg ? V_U : V_I;
            vpos  = pos_iu_reg;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        has_a_next   = has_a_reg;
        has_e_next   = has_e_reg;
        has_o_next   = has_o_reg;
        has_iu_next  = has_iu_reg;
        pos_a_next   = pos_a_reg;
        pos_e_next   = pos_e_reg;
        pos_o_next   = pos_o_reg;
        pos_iu_next  = pos_iu_reg;
        iu_is_u_next = iu_is_u_reg;
        idx_next     = idx_reg;
        if (cmd.take_item && !is_eos && !is_digit && is_full)
        begin
            ovf_next = 1'b1;
        end
        if (do_write)
        begin
            count_next = count_reg + CW'(1);
            if ((folded == CH_A) && !has_a_reg)
            begin
                has_a_next = 1'b1;
                pos_a_next = wr_idx;
            end
            if ((folded == CH_E) && !has_e_reg)
            begin
                has_e_next = 1'b1;
                pos_e_next = wr_idx;
            end
            if ((folded == CH_O) && !has_o_reg)
            begin
                has_o_next = 1'b1;
                pos_o_next = wr_idx;
            end
            if ((folded == CH_I) || (folded == CH_U))
            begin
                has_iu_next  = 1'b1;
                pos_iu_next  = wr_idx;
                iu_is_u_next = (folded == CH_U);
            end
        end
        if (cmd.take_item && stat.run_start)
        begin
            idx_next = '0;
        end
        else if (cmd.emit_step)
        begin
            idx_next = idx_reg + IW'(1);
        end
        if (do_clear)
        begin
            count_next  = '0;
            ovf_next    = 1'b0;
            has_a_next  = 1'b0;
            has_e_next  = 1'b0;
            has_o_next  = 1'b0;
            has_iu_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            has_a_reg   <= 1'b0;
            has_e_reg   <= 1'b0;
            has_o_reg   <= 1'b0;
            has_iu_reg  <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            has_a_reg   <= has_a_next;
            has_e_reg   <= has_e_next;
            has_o_reg   <= has_o_next;
            has_iu_reg  <= has_iu_next;
            idx_reg     <= idx_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pos_a_reg   <= pos_a_next;
        pos_e_reg   <= pos_e_next;
        pos_o_reg   <= pos_o_next;
        pos_iu_reg  <= pos_iu_next;
        iu_is_u_reg <= iu_is_u_next;
        if (do_write)
        begin
            store_mem[wr_idx] <= folded;
        end
        if (cmd.take_item && stat.run_start)
        begin
            marked_reg <= !is_tone5 && any_vowel;
            pos_reg    <= vpos;
            mark_reg   <= TONE_TABLE[{vcode, tone_ofs}];
        end
        if (cmd.emit_step)
        begin
            result_reg.out_char   <= (marked_reg && (idx_reg == pos_reg))
                                     ? mark_reg : store_mem[idx_reg];
            result_reg.run_last   <= stat.emit_last;
            result_reg.overflowed <= ovf_reg;
        end
    end

    assign result = result_reg;

endmodule

// File: rtl/pinyin_tone_marker.sv
// top level of the pinyin tone marker: controller and datapath
`timescale 1ns / 1ps
// Usage:
//   item channel (item, item_valid, item_stall) carries one UTF-16 code unit
//   per request, or an end_of_string marker. Letters are buffered, a digit
//   1 to 4 marks one vowel and releases the syllable, digit 5 releases it
//   unmarked, other digits are ignored, end_of_string drops the syllable.
//   result channel (result, result_valid, result_stall) carries one character
//   per transfer; run_last flags the final one, overflowed flags a syllable
//   that lost letters to a full buffer.
// Flow:
//   a letter, ignored digit or end marker is taken and the next
//   request is taken right away. A tone digit releasing n letters holds the
//   item channel while the characters are stepped out of the buffer one
//   per cycle, when the result is not stalled, through the output register;
//   the digit moves the controller to ST_EMIT, then the first character is
//   loaded into the output register.
// Reset: asynchronous, clears the letter count, the overflow flag and the
//   output valid; buffer contents are not cleared.
// Stall: a stalled result holds its register; the emission pauses and the
//   item channel stays stalled until the last character is loaded.
module pinyin_tone_marker #(
    parameter int MAX_SYLLABLE = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ptm_pkg::item_t   item,
    input  logic             item_valid,
    output logic             item_stall,
    output ptm_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);
    import ptm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: request acceptance and output pacing
    ptm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // buffer, vowel tracking and tone lookup
    ptm_dpath #(
        .MAX_SYLLABLE (MAX_SYLLABLE)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

// File: rtl/ptm_checker.sv
// port-level checks for the pinyin tone marker, bound to the top level
`timescale 1ns / 1ps
module ptm_checker (
    input logic             clk,
    input logic             rst_n,
    input ptm_pkg::item_t   item,
    input logic             item_valid,
    input logic             item_stall,
    input ptm_pkg::result_t result,
    input logic             result_valid,
    input logic             result_stall
);
    import ptm_pkg::*;

    logic item_take, result_take, item_letter;

    assign item_take   = item_valid && !item_stall;
    assign result_take = result_valid && !result_stall;
    assign item_letter = !item.end_of_string &&
                         ((item.in_char < CH_0) || (item.in_char > CH_9));

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // end marker never starts a run
    a_eos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && item.end_of_string |=> !item_stall)
        else $error("end marker left item channel stalled");

    // letters are only buffered
    a_letter_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && item_letter |=> !item_stall)
        else $error("letter left item channel stalled");

    // a run continues without a gap when the receiver is ready
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_take && !result.run_last |=> result_valid)
        else $error("run broke before its last character");

endmodule

bind pinyin_tone_marker ptm_checker u_ptm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);

// File: tb/pinyin_tone_marker_tb.sv
// self-checking testbench for the pinyin tone marker: directed table, then random syllables
`timescale 1ns / 1ps
module pinyin_tone_marker_tb;
    import ptm_pkg::*;

    localparam int MAX_SYL      = 8;
    localparam int RAND_ITEMS   = 405;
    localparam int TONE_NEUTRAL = 5;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AFTER   = 40;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_NS     = 2000000;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        item_t       it;
        logic        typed;
        logic        one_char;
        logic [15:0] exp_char;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    item_t   item;
    logic    item_valid;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall;

    // predicted copy of the block's syllable state
    logic [15:0] syl_buf [MAX_SYL];
    int          syl_len = 0;
    logic        syl_overflow = 1'b0;

    // characters released by the last request, as predicted
    result_t     run_buf [MAX_SYL];
    int          run_len = 0;

    result_t     pending_chars [$];
    stim_row_t   stim_rows [$];
    result_t     want;
    int          errors = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          items_sent = 0;

    pinyin_tone_marker #(
        .MAX_SYLLABLE(MAX_SYL)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(LIMIT_NS);
        $display("pinyin_tone_marker_tb failed");
        $finish;
    end

    // predicts the characters one request releases and updates the syllable state
    task automatic accent_syllable(input item_t it);
        logic [15:0] c;
        logic [15:0] want_ch;
        logic [2:0]  want_row;
        logic [2:0]  row;
        int          tone;
        int          pos;
        int          i;
        int          k;
        bit          found;
        c        = it.in_char;
        run_len  = 0;
        found    = 1'b0;
        pos      = 0;
        row      = V_A;
        want_ch  = CH_A;
        want_row = V_A;
        // end of string drops whatever is pending
        if (it.end_of_string)
        begin
            syl_len      = 0;
            syl_overflow = 1'b0;
            return;
        end
        // anything but a digit is a letter; fold ascii capitals
        if (c < CH_0 || c > CH_9)
        begin
            if (c >= CH_UP_A && c <= CH_UP_Z)
                c = c + CASE_OFS;
            if (syl_len < MAX_SYL)
            begin
                syl_buf[syl_len] = c;
                syl_len++;
            end
            else
                syl_overflow = 1'b1;
            return;
        end
        tone = int'(c - CH_0);
        // digits 0 and 6 to 9 are dropped silently
        if (tone < 1 || tone > TONE_NEUTRAL)
            return;
        if (tone < TONE_NEUTRAL)
        begin
            // a, then e, then o, first occurrence wins
            for (k = 0; k < 3 && !found; k++)
            begin
                case (k)
                    0:
                    begin
                        want_ch  = CH_A;
                        want_row = V_A;
                    end
                    1:
                    begin
                        want_ch  = CH_E;
                        want_row = V_E;
                    end
                    default:
                    begin
                        want_ch  = CH_O;
                        want_row = V_O;
                    end
                endcase
                for (i = 0; i < syl_len && !found; i++)
                begin
                    if (syl_buf[i] == want_ch)
                    begin
                        pos   = i;
                        row   = want_row;
                        found = 1'b1;
                    end
                end
            end
            // otherwise the last i or u takes the mark
            if (!found)
            begin
                for (i = 0; i < syl_len; i++)
                begin
                    if (syl_buf[i] == CH_I)
                    begin
                        pos   = i;
                        row   = V_I;
                        found = 1'b1;
                    end
                    else if (syl_buf[i] == CH_U)
                    begin
                        pos   = i;
                        row   = V_U;
                        found = 1'b1;
                    end
                end
            end
        end
        for (i = 0; i < syl_len; i++)
        begin
            if (found && i == pos)
                run_buf[i].out_char = TONE_TABLE[int'(row) * 4 + tone - 1];
            else
                run_buf[i].out_char = syl_buf[i];
            run_buf[i].run_last   = (i + 1 == syl_len);
            run_buf[i].overflowed = syl_overflow;
        end
        run_len      = syl_len;
        syl_len      = 0;
        syl_overflow = 1'b0;
    endtask

    // offers one request, predicts at the accepting edge, then may idle a while
    task automatic send_item(input stim_row_t row);
        result_t typed_char;
        int      gap;
        int      r;
        int      i;
        item       <= row.it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        accent_syllable(row.it);
        if (row.typed)
        begin
            if (row.one_char)
            begin
                typed_char.out_char   = row.exp_char;
                typed_char.run_last   = 1'b1;
                typed_char.overflowed = 1'b0;
                pending_chars.push_back(typed_char);
            end
        end
        else
        begin
            for (i = 0; i < run_len; i++)
                pending_chars.push_back(run_buf[i]);
        end
        items_sent++;
        // every third stretch of 40 requests goes back to back
        if ((items_sent / 40) % 3 == 1)
            gap = 0;
        else
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                gap = 0;
            else if (r < 9)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 25);
        end
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_char(input logic [15:0] c, input logic eos);
        stim_row_t row;
        row.it.in_char       = c;
        row.it.end_of_string = eos;
        row.typed            = 1'b0;
        row.one_char         = 1'b0;
        row.exp_char         = '0;
        send_item(row);
    endtask

    // directed table entry; typed rows yield no character or one lone one
    task automatic add_row(input logic [15:0] c, input logic eos, input logic typed,
                           input logic one_char, input logic [15:0] exp_char);
        stim_row_t row;
        row.it.in_char       = c;
        row.it.end_of_string = eos;
        row.typed            = typed;
        row.one_char         = one_char;
        row.exp_char         = exp_char;
        stim_rows.push_back(row);
    endtask

    // sender stops offering until every predicted character is back
    task automatic drain_expected();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // mostly pinyin letters, some capitals and some arbitrary code units
    function automatic logic [15:0] rand_letter();
        logic [15:0] c;
        int          sel;
        sel = $urandom_range(0, 19);
        if (sel < 8)
        begin
            case ($urandom_range(0, 4))
                0:       c = CH_A;
                1:       c = CH_E;
                2:       c = CH_I;
                3:       c = CH_O;
                default: c = CH_U;
            endcase
        end
        else if (sel < 15)
            c = 16'(CH_A + $urandom_range(0, 25));
        else if (sel < 17)
            c = 16'(CH_UP_A + $urandom_range(0, 25));
        else
        begin
            c = 16'($urandom);
            // keep it a letter, never a digit
            if (c >= CH_0 && c <= CH_9)
                c = ~c;
        end
        return c;
    endfunction

    // result side: compare each accepted character with the oldest prediction
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
        begin
            results_seen <= results_seen + 1;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, result);
                errors = errors + 1;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (result.out_char !== want.out_char)
                begin
                    $display("%0t: out_char expected %h got %h",
                             $time, want.out_char, result.out_char);
                    errors = errors + 1;
                end
                if (result.run_last !== want.run_last)
                begin
                    $display("%0t: run_last expected %b got %b",
                             $time, want.run_last, result.run_last);
                    errors = errors + 1;
                end
                if (result.overflowed !== want.overflowed)
                begin
                    $display("%0t: overflowed expected %b got %b",
                             $time, want.overflowed, result.overflowed);
                    errors = errors + 1;
                end
            end
        end
    end

    // receiver stalls: short and long bursts, calm stretches, and one long hold-off
    initial
    begin
        int stall_left;
        bit held_long;
        stall_left = 0;
        held_long  = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (!held_long && results_seen >= HOLD_AFTER)
            begin
                // long hold so the item side backs up
                held_long  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && (cycle_count / 150) % 3 != 2
                     && $urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(1, 3);
            if (stall_left != 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [15:0] c;
        logic [15:0] d;
        int          counted;
        int          len;
        int          term;
        int          k;
        bit          paused;
        counted = 0;
        paused  = 1'b0;
        item       <= '0;
        item_valid <= 1'b0;
        rst_n      <= 1'b0;

        // single-vowel syllables, tone 1 and a folded capital with tone 2
        add_row(CH_A, 1'b0, 1'b1, 1'b0, 16'h0000);
        add_row(CH_1, 1'b0, 1'b1, 1'b1, 16'h0101);
        add_row(16'(CH_UP_A + 4), 1'b0, 1'b1, 1'b0, 16'h0000);
        add_row(16'(CH_1 + 1), 1'b0, 1'b1, 1'b1, 16'h00E9);
        // tone digit on an empty syllable releases nothing
        add_row(CH_1, 1'b0, 1'b1, 1'b0, 16'h0000);
        // all-zero code unit released unmarked by the neutral tone
        add_row(16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000);
        add_row(CH_5, 1'b0, 1'b1, 1'b1, 16'h0000);
        // ignored digits inside a syllable with no vowel
        add_row(16'(CH_A + 12), 1'b0, 1'b1, 1'b0, 16'h0000);
        add_row(CH_0, 1'b0, 1'b1, 1'b0, 16'h0000);
        add_row(CH_9, 1'b0, 1'b1, 1'b0, 16'h0000);
        add_row(16'(CH_1 + 2), 1'b0, 1'b1, 1'b1, 16'(CH_A + 12));
        // all-ones letter, then end of string drops it
        add_row(16'hFFFF, 1'b0, 1'b1, 1'b0, 16'h0000);
        add_row(16'hFFFF, 1'b1, 1'b1, 1'b0, 16'h0000);
        // full buffer plus one dropped letter, tone 4 on the a
        add_row(CH_UP_Z, 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(16'(CH_A + 7), 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(CH_U, 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(CH_A, 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(16'(CH_A + 13), 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(16'(CH_A + 6), 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(16'(CH_A + 18), 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(16'(CH_A + 7), 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(16'(CH_1 + 3), 1'b0, 1'b0, 1'b0, 16'h0000);
        // i and u together: the later one takes the mark
        add_row(16'(CH_A + 11), 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(CH_I, 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(CH_U, 1'b0, 1'b0, 1'b0, 16'h0000);
        add_row(16'(CH_1 + 2), 1'b0, 1'b0, 1'b0, 16'h0000);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_item(stim_rows[i]);
        drain_expected();

        // random syllables: letters, then a tone, end of string or nothing
        while (counted < RAND_ITEMS)
        begin
            if (!paused && counted >= RAND_ITEMS / 2)
            begin
                paused = 1'b1;
                drain_expected();
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_SYL + 1, MAX_SYL + 3)
                                              : $urandom_range(0, 6);
            for (k = 0; k < len; k++)
            begin
                send_char(rand_letter(), 1'b0);
                counted++;
                // now and then a digit the block ignores
                if ($urandom_range(0, 11) == 0)
                begin
                    d = 16'($urandom_range(0, 4));
                    c = (d == 16'd0) ? CH_0 : (CH_0 + d + 16'd5);
                    send_char(c, 1'b0);
                end
            end
            term = $urandom_range(0, 19);
            if (term < 14)
                send_char(16'(CH_1 + $urandom_range(0, 3)), 1'b0);
            else if (term < 17)
                send_char(CH_5, 1'b0);
            else if (term < 19)
                send_char(16'($urandom), 1'b1);
            if (term < 19)
                counted++;
        end

        drain_expected();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("pinyin_tone_marker_tb passed");
        else
            $display("pinyin_tone_marker_tb failed");
        $finish;
    end

endmodule

// File: files.f
rtl/ptm_pkg.sv
rtl/ptm_ctrl.sv
rtl/ptm_dpath.sv
rtl/pinyin_tone_marker.sv
rtl/ptm_checker.sv
tb/pinyin_tone_marker_tb.sv
